// ===== src/iireqt_pkg.sv =====
// Package for the equal-tap IIR filter: sizes, register indexes and the sequencer
// state type. Used by iir_equal_tap_filter_unit. Depends on nothing else.
`default_nettype none

package iireqt_pkg;

   // Filter length: one current-sample term plus TAPS-1 delays on each side.
   localparam int TAPS       = 8;
   localparam bit HAS_HIST   = (TAPS > 1);
   localparam int HIST_D     = (TAPS > 1) ? TAPS - 1 : 1;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = SAMPLE_W + GAIN_W;

   // Terms per output: current sample, TAPS-1 inputs, TAPS-1 outputs.
   localparam int TERMS      = 2 * TAPS - 1;
   localparam int STEP_W     = $clog2(TERMS + 1);
   localparam int ACC_W      = PROD_W + $clog2(2 * TAPS);

   // Q2.30 -> Q1.15: add half an LSB, then drop 15 bits.
   localparam int FRAC_SHIFT = 15;
   localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_FORWARD_GAIN  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK_GAIN = CSR_INDEX_W'(1);

   localparam logic signed [GAIN_W-1:0] FORWARD_GAIN_RST  = GAIN_W'(3277);
   localparam logic signed [GAIN_W-1:0] FEEDBACK_GAIN_RST = GAIN_W'(16384);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MAC    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== src/iir_equal_tap_filter_unit.sv =====
// Top level of the equal-tap direct-form-I IIR filter: sequencer, shared MAC,
// history shift lines and configuration registers. Depends on iireqt_pkg.
`default_nettype none

//  channel   direction  handshake                payload
//  req_*     in         req_valid / req_ready    sample_in (s16 Q1.15), first
//  rsp_*     out        rsp_valid / rsp_ready    sample_out (s16 Q1.15), clipped
//  csr_*     in         csr_valid / csr_ready    index (0 fwd gain, 1 fb gain), data
//
//  A sample is taken in the idle state, then its 2*TAPS-1 terms pass one by one
//  through the single 16x16 multiply-accumulate, and the finish state rounds,
//  saturates and retires it. The MAC sets the rate; no new sample is taken until the last one retires.
//  Reset clears the gains to their defaults, both histories and the result flag.
//  A pending result stalls only the retire step; req_ready drops while busy.

module iir_equal_tap_filter_unit
   import iireqt_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic signed [SAMPLE_W-1:0]    req_sample_in,
   input  wire logic                          req_first,

   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic signed [SAMPLE_W-1:0]    rsp_sample_out,
   output      logic                          rsp_clipped,

   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [GAIN_W-1:0]             csr_data
);

   localparam int RND_W = ACC_W + 1;
   localparam int TOP_W = RND_W - (FRAC_SHIFT + SAMPLE_W - 1);

   state_type                     state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]    x_ff, x_in;
   logic signed [SAMPLE_W-1:0]    in_hist_ff  [HIST_D];
   logic signed [SAMPLE_W-1:0]    in_hist_in  [HIST_D];
   logic signed [SAMPLE_W-1:0]    out_hist_ff [HIST_D];
   logic signed [SAMPLE_W-1:0]    out_hist_in [HIST_D];
   logic signed [GAIN_W-1:0]      fwd_gain_ff, fb_gain_ff;
   logic signed [SAMPLE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                          rsp_clipped_ff, rsp_clipped_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          req_fire;
   logic                          is_fb;
   logic                          last_step;
   logic                          retire;
   logic signed [GAIN_W-1:0]      mul_a;
   logic signed [SAMPLE_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]      prod;
   logic signed [RND_W-1:0]       rnd_sum;
   logic [TOP_W-1:0]              rnd_top;
   logic                          in_range;
   logic signed [SAMPLE_W-1:0]    y_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   // Step 0 is the current sample, then TAPS-1 input delays, then TAPS-1 output delays.
   assign is_fb     = (step_ff >= STEP_W'(TAPS));
   assign last_step = (step_ff == STEP_W'(TERMS - 1));
   assign retire    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Shared MAC: the head of each history line is always the next term.
   assign mul_a = is_fb ? fb_gain_ff : fwd_gain_ff;
   always_comb begin
      priority if (step_ff == '0) begin
         mul_b = x_ff;
      end else if (is_fb) begin
         mul_b = out_hist_ff[0];
      end else begin
         mul_b = in_hist_ff[0];
      end
   end
   assign prod = mul_a * mul_b;

   // Round half up and saturate: in range when the bits above the sign agree.
   assign rnd_sum  = RND_W'(acc_ff) + RND_W'(ROUND_HALF);
   assign rnd_top  = rnd_sum[RND_W-1:FRAC_SHIFT+SAMPLE_W-1];
   assign in_range = (rnd_top == '0) || (rnd_top == '1);
   always_comb begin
      priority if (in_range) begin
         y_sat = rnd_sum[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
      end else if (rnd_sum[RND_W-1]) begin
         y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // Sequencer, accumulator and result register.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      acc_in         = acc_ff;
      x_in           = x_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_clipped_in = rsp_clipped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in     = req_sample_in;
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            acc_in  = is_fb ? acc_ff - ACC_W'(prod) : acc_ff + ACC_W'(prod);
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (retire) begin
               rsp_sample_in  = y_sat;
               rsp_clipped_in = !in_range;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // History lines: cleared on a first sample, rotated once per term during the
   // MAC so they end in their original order, shifted on retire.
   always_comb begin
      in_hist_in  = in_hist_ff;
      out_hist_in = out_hist_ff;
      if (req_fire && req_first) begin
         for (int i = 0; i < HIST_D; i++) begin
            in_hist_in[i]  = '0;
            out_hist_in[i] = '0;
         end
      end else if (HAS_HIST && state_ff == ST_MAC && step_ff != '0) begin
         if (is_fb) begin
            for (int i = 0; i < HIST_D - 1; i++) begin
               out_hist_in[i] = out_hist_ff[i+1];
            end
            out_hist_in[HIST_D-1] = out_hist_ff[0];
         end else begin
            for (int i = 0; i < HIST_D - 1; i++) begin
               in_hist_in[i] = in_hist_ff[i+1];
            end
            in_hist_in[HIST_D-1] = in_hist_ff[0];
         end
      end else if (HAS_HIST && retire) begin
         for (int i = 1; i < HIST_D; i++) begin
            in_hist_in[i]  = in_hist_ff[i-1];
            out_hist_in[i] = out_hist_ff[i-1];
         end
         in_hist_in[0]  = x_ff;
         out_hist_in[0] = y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_gain_ff  <= FORWARD_GAIN_RST;
         fb_gain_ff   <= FEEDBACK_GAIN_RST;
         for (int i = 0; i < HIST_D; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         in_hist_ff   <= in_hist_in;
         out_hist_ff  <= out_hist_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FORWARD_GAIN) begin
               fwd_gain_ff <= csr_data;
            end else if (csr_index == REG_FEEDBACK_GAIN) begin
               fb_gain_ff <= csr_data;
            end
         end
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      x_ff           <= x_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

endmodule

`default_nettype wire
